// ===== design/wvosc_pkg.sv =====
// shared types and constants for the wavetable voice oscillator
// no dependencies; imported by the core and its port checker
package wvosc_pkg;

    // wavetable size, power of two from 16 to 1024, the reach of the 10-bit table_index
    localparam int TABLE_DEPTH = 1024;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);

    // item kinds carried on s_tuser
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_RENDER  = 2'd2;

    // configuration register indexes
    localparam int          CFG_IDX_W       = 2;
    localparam logic [1:0]  REG_PHASE_STEP  = 2'd0;
    localparam logic [1:0]  REG_NOISE_AMT   = 2'd1;
    localparam logic [1:0]  REG_LP_COEFF    = 2'd2;
    localparam int          CFG_DATA_W      = 32;

    // noise seeding on restart
    localparam logic [31:0] SEED_XOR  = 32'h9e3779b9;
    localparam logic [31:0] SEED_MULT = 32'd2654435761;

    // input word fields, lowest field last
    typedef struct packed {
        logic [15:0]        gain_right;
        logic [15:0]        gain_left;
        logic [31:0]        voice_age;
        logic signed [15:0] table_value;
        logic [9:0]         table_index;
    } in_word_t;

    // output word fields
    typedef struct packed {
        logic signed [15:0] right_sample;
        logic signed [15:0] left_sample;
    } out_word_t;

    localparam int IN_FIELDS_W = $bits(in_word_t);
    localparam int S_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = $bits(out_word_t);

endpackage

// ===== design/wavetable_voice_oscillator_core.sv =====
// wavetable voice: interpolated table read, noise crossfade, one-pole lowpass, stereo gain
// depends on wvosc_pkg
// a render word passes read, interpolate, noise, filter and gain steps, then m_tvalid
// throughput: one render at a time (two reads on the table read port, then interpolate,
//   noise, filter, gain waits on m_tready); write and restart words every cycle when idle
// reset: phase, filter and config cleared, noise set to one; table content undefined
module wavetable_voice_oscillator_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    // config write port
    input  logic                              cfg_wr_en,
    input  logic [wvosc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wvosc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // table_index[9:0], table_value[25:10], voice_age[57:26],
    // gain_left[73:58], gain_right[89:74], zero fill above
    input  logic [wvosc_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode[1:0]
    input  logic [1:0]                        s_tuser,
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // left_sample[15:0], right_sample[31:16]
    output logic [wvosc_pkg::M_TDATA_W-1:0]   m_tdata
);
    import wvosc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ_B = 3'd1;
    localparam logic [2:0] S_INTERP = 3'd2;
    localparam logic [2:0] S_NOISE  = 3'd3;
    localparam logic [2:0] S_FILT   = 3'd4;
    localparam logic [2:0] S_GAIN   = 3'd5;

    function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
        if (v > 21'sd32767)
            return 16'sh7fff;
        else if (v < -21'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    function automatic logic signed [16:0] sat17(input logic signed [20:0] v);
        if (v > 21'sd65535)
            return 17'sh0ffff;
        else if (v < -21'sd65536)
            return 17'sh10000;
        else
            return v[16:0];
    endfunction

    in_word_t               in_w;
    logic                   s_acc;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [31:0]            phase_reg;
    logic [31:0]            noise_reg;
    logic signed [16:0]     filt_reg;
    logic [31:0]            phase_step_reg;
    logic [15:0]            noise_amt_reg;
    logic [15:0]            lowpass_k_reg;

    logic [TBL_AW-1:0]      idx_reg;
    logic [15:0]            frac_reg;
    logic [15:0]            gl_reg;
    logic [15:0]            gr_reg;
    logic signed [15:0]     a_reg;
    logic signed [16:0]     smp_reg;
    logic signed [16:0]     smp_next;
    logic                   m_tvalid_reg;
    out_word_t              m_tdata_reg;

    // wavetable memory
    logic [15:0]            wave_mem [TABLE_DEPTH];
    logic                   mem_we;
    logic [TBL_AW-1:0]      wr_addr;
    logic [TBL_AW-1:0]      rd_addr;
    logic signed [15:0]     rd_data_reg;

    // datapath
    logic [31:0]            seed_prod;
    logic [31:0]            seed;
    logic [31:0]            xs1;
    logic [31:0]            xs2;
    logic [31:0]            xs3;
    logic signed [16:0]     ip_diff;
    logic signed [16:0]     frac_s;
    logic signed [33:0]     ip_prod;
    logic signed [17:0]     ip_sum;
    logic signed [15:0]     nz;
    logic signed [17:0]     nm_diff;
    logic signed [16:0]     amt_s;
    logic signed [34:0]     nm_prod;
    logic signed [20:0]     nm_sum;
    logic signed [17:0]     lp_diff;
    logic signed [16:0]     coeff_s;
    logic signed [34:0]     lp_prod;
    logic signed [20:0]     lp_sum;
    logic signed [16:0]     lp_sat;
    logic signed [16:0]     gl_s;
    logic signed [16:0]     gr_s;
    logic signed [33:0]     gl_prod;
    logic signed [33:0]     gr_prod;
    logic                   out_free;

    assign in_w     = in_word_t'(s_tdata[IN_FIELDS_W-1:0]);
    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // table port: write from a write word, read a at accept, b in the next cycle
    assign mem_we  = s_acc && (s_tuser == OP_WRITE);
    assign wr_addr = TBL_AW'(in_w.table_index);
    assign rd_addr = (state_reg == S_IDLE) ? phase_reg[31 -: TBL_AW]
                                           : TBL_AW'(idx_reg + 1'b1);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            wave_mem[wr_addr] <= in_w.table_value;
        end
        rd_data_reg <= wave_mem[rd_addr];
    end

    // restart seed
    assign seed_prod = 32'(in_w.voice_age * SEED_MULT);
    assign seed      = SEED_XOR ^ seed_prod;

    // xorshift32 advance
    assign xs1 = noise_reg ^ (noise_reg << 13);
    assign xs2 = xs1 ^ (xs1 >> 17);
    assign xs3 = xs2 ^ (xs2 << 5);

    // linear interpolation, b in rd_data_reg
    assign ip_diff = 17'(rd_data_reg) - 17'(a_reg);
    assign frac_s  = $signed({1'b0, frac_reg});
    assign ip_prod = 34'(ip_diff) * 34'(frac_s);
    assign ip_sum  = 18'(a_reg) + $signed(ip_prod[33:16]);

    // noise crossfade, top half of noise minus 32768
    assign nz      = $signed({~noise_reg[31], noise_reg[30:16]});
    assign nm_diff = 18'(nz) - 18'(smp_reg);
    assign amt_s   = $signed({1'b0, noise_amt_reg});
    assign nm_prod = 35'(nm_diff) * 35'(amt_s);
    assign nm_sum  = 21'(smp_reg) + 21'($signed(nm_prod[34:15]));

    // one-pole lowpass
    assign lp_diff = 18'(smp_reg) - 18'(filt_reg);
    assign coeff_s = $signed({1'b0, lowpass_k_reg});
    assign lp_prod = 35'(lp_diff) * 35'(coeff_s);
    assign lp_sum  = 21'(filt_reg) + 21'($signed(lp_prod[34:15]));
    assign lp_sat  = sat17(lp_sum);

    // stereo gain
    assign gl_s    = $signed({1'b0, gl_reg});
    assign gr_s    = $signed({1'b0, gr_reg});
    assign gl_prod = 34'(smp_reg) * 34'(gl_s);
    assign gr_prod = 34'(smp_reg) * 34'(gr_s);

    always_comb
    begin
        state_next = state_reg;
        smp_next   = smp_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_acc && (s_tuser == OP_RENDER))
                    state_next = S_READ_B;
            end
            S_READ_B:
            begin
                state_next = S_INTERP;
            end
            S_INTERP:
            begin
                smp_next   = ip_sum[16:0];
                state_next = S_NOISE;
            end
            S_NOISE:
            begin
                if (noise_amt_reg != 16'd0)
                    smp_next = 17'(sat16(nm_sum));
                state_next = S_FILT;
            end
            S_FILT:
            begin
                if (lowpass_k_reg != 16'd0)
                    smp_next = lp_sat;
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= 32'd0;
            noise_reg      <= 32'd1;
            filt_reg       <= 17'sd0;
            phase_step_reg <= 32'd0;
            noise_amt_reg  <= 16'd0;
            lowpass_k_reg  <= 16'd0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_PHASE_STEP: phase_step_reg <= cfg_wdata;
                    REG_NOISE_AMT:  noise_amt_reg  <= cfg_wdata[15:0];
                    REG_LP_COEFF:   lowpass_k_reg  <= cfg_wdata[15:0];
                    default:        ;
                endcase
            end

            if (s_acc && (s_tuser == OP_RESTART))
            begin
                phase_reg <= 32'd0;
                filt_reg  <= 17'sd0;
                noise_reg <= (seed == 32'd0) ? 32'd1 : seed;
            end
            else if (s_acc && (s_tuser == OP_RENDER))
            begin
                phase_reg <= phase_reg + phase_step_reg;
            end

            if ((state_reg == S_INTERP) && (noise_amt_reg != 16'd0))
                noise_reg <= xs3;

            if ((state_reg == S_FILT) && (lowpass_k_reg != 16'd0))
                filt_reg <= lp_sat;

            if ((state_reg == S_GAIN) && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        smp_reg <= smp_next;
        if (s_acc)
        begin
            idx_reg  <= phase_reg[31 -: TBL_AW];
            frac_reg <= phase_reg[31-TBL_AW -: 16];
            gl_reg   <= in_w.gain_left;
            gr_reg   <= in_w.gain_right;
        end
        if (state_reg == S_READ_B)
            a_reg <= rd_data_reg;
        if ((state_reg == S_GAIN) && out_free)
        begin
            m_tdata_reg.left_sample  <= sat16($signed(gl_prod[33:13]) >>> 2);
            m_tdata_reg.right_sample <= sat16($signed(gr_prod[33:13]) >>> 2);
        end
    end

endmodule

// ===== design/wvosc_port_check.sv =====
// port-level checks for the wavetable voice core, bound to its top level
// depends on wvosc_pkg and wavetable_voice_oscillator_core
module wvosc_port_check
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [1:0]                        s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [wvosc_pkg::M_TDATA_W-1:0]   m_tdata
);
    import wvosc_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // a render word occupies the core
    a_render_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_RENDER) |=> !s_tready)
        else $error("input ready right after a render word");

    // write and restart words never stall the input
    a_other_free: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser != OP_RENDER) |=> s_tready)
        else $error("input stalled after a write or restart word");

    // a new result only comes out of a render in progress
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result word without a render in progress");

endmodule

bind wavetable_voice_oscillator_core wvosc_port_check u_wvosc_port_check
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
